// ===== rtl/core/assert_macros.svh =====
// Assertion macros shared by the decoder RTL.
// Define NO_ASSERTIONS to compile every macro to nothing.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef NO_ASSERTIONS
// Clocked property that is switched off while the active-low reset is asserted.
`define ASSERT_CLK(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
// Clocked property that must also hold during reset.
`define ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define ASSERT_CLK(lbl, clk, rst_n, prop, msg)
`define ASSERT_ALWAYS(lbl, clk, prop, msg)
`endif
`endif

// ===== rtl/core/bmpd_pkg.sv =====
// Shared types and constants of the BMP pixel stream decoder.
// No dependencies; used by the parser, the palette memory and the top level.
package bmpd_pkg;

  localparam logic [15:0] SIGNATURE    = 16'h4D42;
  localparam logic [31:0] HEADER_BYTES = 32'd54;
  // The palette of an 8-bit file occupies 1024 bytes after the info header.
  localparam logic [31:0] PALETTE_END  = 32'd1078;

  typedef enum logic [1:0] {
    KIND_PIXEL       = 2'd0,
    KIND_HEADER_OK   = 2'd1,
    KIND_BAD_HEADER  = 2'd2,
    KIND_UNSUPPORTED = 2'd3
  } kind_e;

  typedef struct packed {
    kind_e       kind;
    logic [11:0] column;
    logic [11:0] row;
    logic [7:0]  red;
    logic [7:0]  green;
    logic [7:0]  blue;
    logic [12:0] image_width;
    logic [12:0] image_height;
    logic        last_pixel;
  } res_t;

  typedef struct packed {
    logic       en;
    logic [7:0] addr;
    logic [1:0] lane;
    logic [7:0] data;
  } pal_wr_t;

endpackage

// ===== rtl/core/bmp_pixel_stream_decoder_unit.sv =====
// Top level of the BMP pixel stream decoder: stream ports and the result pipeline.
// Depends on bmpd_pkg, bmpd_parser, bmpd_palette and assert_macros.svh.
//
// Usage: the bytes of a BMP file enter on the slave stream, one byte per word,
// with tlast on the final byte of the file. The decoder checks the 14-byte
// file header and the 40-byte info header and then walks the pixel array of
// 8-bit palette, 24-bit or 32-bit files, dropping row padding.
// The master stream carries one word per result: tuser gives the kind (pixel,
// header accepted, bad signature or offset, unsupported depth or size), tdata
// carries position, color and image size, tlast marks the final pixel.
// Throughput is one byte per cycle while the master side does not stall. The
// result of an accepted byte is loaded into the read stage together with the
// registered palette read, and moves on into the output register, from which
// it is presented on the master side. Palette writes and pixel reads
// never touch the memory in the same cycle, since the palette is filled before
// the first pixel byte arrives, so no forwarding is needed.
// When the receiver stalls, the output register and the read stage fill and
// tready drops; no word is lost or repeated. Reset returns the parser to the
// file header; the palette contents survive tlast and are not cleared.
module bmp_pixel_stream_decoder_unit #(
  parameter int MAX_WIDTH  = 4096,
  parameter int MAX_HEIGHT = 4096
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  logic [7:0]  s_axis_tdata_i,  // [7:0] file_byte
  input  logic        s_axis_tlast_i,  // end_of_file
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  // [11:0] column, [23:12] row, [31:24] red, [39:32] green, [47:40] blue,
  // [60:48] image_width, [73:61] image_height, [79:74] zero
  output logic [79:0] m_axis_tdata_o,
  output logic [1:0]  m_axis_tuser_o,  // [1:0] kind
  output logic        m_axis_tlast_o   // last_pixel
);
  import bmpd_pkg::*;
  `include "assert_macros.svh"

  res_t    res, p_res_q, o_res_q, merged;
  logic    res_valid, res_pal;
  pal_wr_t pal_wr;
  logic [7:0]  pal_rd_addr;
  logic [23:0] pal_rd_data;
  logic    s_accept, move;
  logic    p_valid_q, p_pal_q, o_valid_q;

  assign move            = p_valid_q && (!o_valid_q || m_axis_tready_i);
  assign s_axis_tready_o = !p_valid_q || move;
  assign s_accept        = s_axis_tvalid_i && s_axis_tready_o;

  bmpd_parser #(
    .MAX_WIDTH (MAX_WIDTH),
    .MAX_HEIGHT(MAX_HEIGHT)
  ) u_parser (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .accept_i     (s_accept),
    .byte_i       (s_axis_tdata_i),
    .eof_i        (s_axis_tlast_i),
    .res_o        (res),
    .res_valid_o  (res_valid),
    .res_pal_o    (res_pal),
    .pal_wr_o     (pal_wr),
    .pal_rd_addr_o(pal_rd_addr)
  );

  // The read register only advances on an accepted byte, so it stays matched
  // with the result held in the read stage while the output side stalls.
  bmpd_palette u_palette (
    .clk_i    (clk_i),
    .wr_i     (pal_wr),
    .rd_en_i  (s_accept),
    .rd_addr_i(pal_rd_addr),
    .rd_data_o(pal_rd_data)
  );

  always_comb begin
    merged = p_res_q;
    if (p_pal_q) begin
      merged.blue  = pal_rd_data[7:0];
      merged.green = pal_rd_data[15:8];
      merged.red   = pal_rd_data[23:16];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      p_valid_q <= 1'b0;
      p_pal_q   <= 1'b0;
      o_valid_q <= 1'b0;
    end else begin
      if (s_accept) begin
        p_valid_q <= res_valid;
        p_pal_q   <= res_valid && res_pal;
      end else if (move) begin
        p_valid_q <= 1'b0;
      end
      if (move) begin
        o_valid_q <= 1'b1;
      end else if (m_axis_tready_i) begin
        o_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_accept) begin
      p_res_q <= res;
    end
    if (move) begin
      o_res_q <= merged;
    end
  end

  assign m_axis_tvalid_o = o_valid_q;
  assign m_axis_tdata_o  = {6'b000000, o_res_q.image_height, o_res_q.image_width,
                            o_res_q.blue, o_res_q.green, o_res_q.red,
                            o_res_q.row, o_res_q.column};
  assign m_axis_tuser_o  = o_res_q.kind;
  assign m_axis_tlast_o  = o_res_q.last_pixel;

  // A new byte never lands on a read stage whose result cannot leave.
  `ASSERT_CLK(a_no_overwrite, clk_i, rst_ni, (s_accept && p_valid_q) |-> (!o_valid_q || m_axis_tready_i), "read stage overwritten")
  // Back-pressure only appears when both result registers are full and stalled.
  `ASSERT_ALWAYS(a_ready_cause, clk_i, !s_axis_tready_o |-> (p_valid_q && o_valid_q && !m_axis_tready_i), "input stalled without full pipeline")
  // Palette reads are only merged into pixel results.
  `ASSERT_CLK(a_pal_pixel, clk_i, rst_ni, (p_valid_q && p_pal_q) |-> (p_res_q.kind == KIND_PIXEL), "palette data on non-pixel result")
  // A result that moved to the output register is presented in the next cycle.
  `ASSERT_CLK(a_move_shows, clk_i, rst_ni, move |=> o_valid_q, "moved result not presented")

endmodule

// ===== rtl/core/bmpd_palette.sv =====
// 256 x 24-bit palette memory with byte-lane writes and a registered read port.
// Depends on bmpd_pkg for the write request type.
module bmpd_palette (
  input  logic             clk_i,
  input  bmpd_pkg::pal_wr_t wr_i,
  input  logic             rd_en_i,
  input  logic [7:0]       rd_addr_i,
  output logic [23:0]      rd_data_o
);
  import bmpd_pkg::*;

  logic [23:0] mem [0:255];
  logic [23:0] rd_data_q;

  always_ff @(posedge clk_i) begin
    if (wr_i.en) begin
      mem[wr_i.addr][{wr_i.lane, 3'b000} +: 8] <= wr_i.data;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      rd_data_q <= mem[rd_addr_i];
    end
  end

  assign rd_data_o = rd_data_q;

endmodule

// ===== rtl/core/bmpd_parser.sv =====
// Byte parser: header fields, pixel-offset skip, palette capture and pixel walk.
// Depends on bmpd_pkg; drives the palette memory write and read address.
module bmpd_parser #(
  parameter int MAX_WIDTH  = 4096,
  parameter int MAX_HEIGHT = 4096
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              accept_i,
  input  logic [7:0]        byte_i,
  input  logic              eof_i,
  output bmpd_pkg::res_t    res_o,
  output logic              res_valid_o,
  output logic              res_pal_o,
  output bmpd_pkg::pal_wr_t pal_wr_o,
  output logic [7:0]        pal_rd_addr_o
);
  import bmpd_pkg::*;

  localparam int WD_W  = $clog2(MAX_WIDTH + 1);
  localparam int HT_W  = $clog2(MAX_HEIGHT + 1);
  localparam int LEN_W = $clog2(4 * MAX_WIDTH + 4);
  localparam logic [31:0]     MAX_W32 = 32'(MAX_WIDTH);
  localparam logic [31:0]     MAX_H32 = 32'(MAX_HEIGHT);
  localparam logic [WD_W-1:0] MAX_WD  = WD_W'(MAX_WIDTH);
  localparam logic [HT_W-1:0] MAX_HT  = HT_W'(MAX_HEIGHT);

  typedef enum logic [1:0] {PH_HEADER, PH_GAP, PH_PIXELS, PH_DONE} phase_e;
  typedef enum logic [1:0] {DEP_8, DEP_24, DEP_32} depth_e;

  phase_e            phase_q, phase_d;
  depth_e            dep_q, dep_d, dep_new;
  logic [31:0]       bp_q, bp_d, off_q, off_d;
  logic [31:0]       raw_w_q, raw_w_d, raw_h_q, raw_h_d;
  logic [15:0]       sig_q, sig_d, raw_d_q, raw_d_d;
  logic [WD_W-1:0]   width_q, width_d, col_q, col_d, wsat;
  logic [HT_W-1:0]   height_q, height_d, row_q, row_d, hsat;
  logic [LEN_W-1:0]  data_len_q, data_len_d, line_len_q, line_len_d, rbc_q, rbc_d;
  logic [LEN_W-1:0]  w_ext, data_new, data_p3, line_new;
  logic [1:0]        k_q, k_d, k_last;
  logic [23:0]       asm_q, asm_d, asm_nxt;
  logic              dep_ok, dims_ok, in_data, emit, last, pixel_go;
  logic [5:0]        hp;
  logic [1:0]        lane_off, lane_w, lane_h;
  logic [9:0]        rel;
  logic [LEN_W:0]    rbc_inc;
  logic [WD_W:0]     col_inc;
  logic [HT_W:0]     row_inc;

  assign hp       = bp_q[5:0];
  assign lane_off = 2'(hp - 6'd10);
  assign lane_w   = 2'(hp - 6'd18);
  assign lane_h   = 2'(hp - 6'd22);
  assign rel      = 10'(bp_q[9:0] - 10'd54);

  // Saturated dimensions and row lengths, evaluated on the last info-header byte.
  always_comb begin
    if (raw_w_q[31])            wsat = '0;
    else if (raw_w_q > MAX_W32) wsat = MAX_WD;
    else                        wsat = raw_w_q[WD_W-1:0];
    if (raw_h_q[31])            hsat = '0;
    else if (raw_h_q > MAX_H32) hsat = MAX_HT;
    else                        hsat = raw_h_q[HT_W-1:0];
    dims_ok = !raw_w_q[31] && (raw_w_q <= MAX_W32) && !raw_h_q[31] && (raw_h_q <= MAX_H32);
    unique case (raw_d_q)
      16'd8:   begin dep_new = DEP_8;  dep_ok = 1'b1; end
      16'd24:  begin dep_new = DEP_24; dep_ok = 1'b1; end
      16'd32:  begin dep_new = DEP_32; dep_ok = 1'b1; end
      default: begin dep_new = DEP_8;  dep_ok = 1'b0; end
    endcase
    w_ext = LEN_W'(wsat);
    unique case (dep_new)
      DEP_24:  data_new = (w_ext << 1) + w_ext;
      DEP_32:  data_new = w_ext << 2;
      default: data_new = w_ext;
    endcase
    data_p3  = data_new + LEN_W'(3);
    line_new = (dep_new == DEP_32) ? data_new : {data_p3[LEN_W-1:2], 2'b00};
  end

  // Pixel walk helpers.
  always_comb begin
    unique case (dep_q)
      DEP_24:  k_last = 2'd2;
      DEP_32:  k_last = 2'd3;
      default: k_last = 2'd0;
    endcase
    asm_nxt = asm_q;
    if (k_q == 2'd0)      asm_nxt = {16'h0000, byte_i};
    else if (k_q != 2'd3) asm_nxt[{k_q, 3'b000} +: 8] = byte_i;
    in_data = rbc_q < data_len_q;
    emit    = in_data && (k_q == k_last);
    rbc_inc = {1'b0, rbc_q} + 1'b1;
    col_inc = {1'b0, col_q} + 1'b1;
    row_inc = {1'b0, row_q} + 1'b1;
    last    = (row_inc == {1'b0, height_q}) && (col_inc == {1'b0, width_q});
  end

  always_comb begin
    phase_d = phase_q;   dep_d = dep_q;       bp_d = bp_q;       off_d = off_q;
    raw_w_d = raw_w_q;   raw_h_d = raw_h_q;   sig_d = sig_q;     raw_d_d = raw_d_q;
    width_d = width_q;   height_d = height_q; col_d = col_q;     row_d = row_q;
    data_len_d = data_len_q; line_len_d = line_len_q; rbc_d = rbc_q;
    k_d = k_q;           asm_d = asm_q;
    res_o = '0;          res_valid_o = 1'b0;  res_pal_o = 1'b0;  pal_wr_o = '0;
    pixel_go = 1'b0;
    pal_rd_addr_o = byte_i;
    if (accept_i) begin
      unique case (phase_q)
        PH_HEADER: begin
          if (hp < 6'd2)                      sig_d[{hp[0], 3'b000} +: 8] = byte_i;
          else if (hp >= 6'd10 && hp <= 6'd13) off_d[{lane_off, 3'b000} +: 8] = byte_i;
          else if (hp >= 6'd18 && hp <= 6'd21) raw_w_d[{lane_w, 3'b000} +: 8] = byte_i;
          else if (hp >= 6'd22 && hp <= 6'd25) raw_h_d[{lane_h, 3'b000} +: 8] = byte_i;
          else if (hp == 6'd28 || hp == 6'd29) raw_d_d[{hp[0], 3'b000} +: 8] = byte_i;
          if (hp == 6'd13 && (sig_q != SIGNATURE || off_d < HEADER_BYTES)) begin
            res_valid_o = 1'b1;
            res_o.kind  = KIND_BAD_HEADER;
            phase_d     = PH_DONE;
          end else begin
            if (hp == 6'd53) begin
              width_d    = wsat;
              height_d   = hsat;
              dep_d      = dep_new;
              data_len_d = data_new;
              line_len_d = line_new;
              res_valid_o = 1'b1;
              res_o.kind  = (dep_ok && dims_ok) ? KIND_HEADER_OK : KIND_UNSUPPORTED;
              res_o.image_width  = 13'(wsat);
              res_o.image_height = 13'(hsat);
              if (!(dep_ok && dims_ok) || wsat == '0 || hsat == '0) phase_d = PH_DONE;
              else                                                  phase_d = PH_GAP;
            end
            bp_d = bp_q + 32'd1;
          end
        end
        PH_GAP: begin
          if (bp_q >= off_q) begin
            phase_d  = PH_PIXELS;
            pixel_go = 1'b1;
          end else begin
            // Palette entries are stored blue, green, red; the reserved byte is dropped.
            if (dep_q == DEP_8 && bp_q < PALETTE_END && rel[1:0] != 2'd3) begin
              pal_wr_o.en   = 1'b1;
              pal_wr_o.addr = rel[9:2];
              pal_wr_o.lane = rel[1:0];
              pal_wr_o.data = byte_i;
            end
            bp_d = bp_q + 32'd1;
          end
        end
        PH_PIXELS: pixel_go = 1'b1;
        default: ;
      endcase

      if (pixel_go) begin
        if (in_data) begin
          asm_d = asm_nxt;
          k_d   = (k_q == k_last) ? 2'd0 : k_q + 2'd1;
        end
        if (emit) begin
          res_valid_o      = 1'b1;
          res_pal_o        = (dep_q == DEP_8);
          res_o.kind       = KIND_PIXEL;
          res_o.column     = 12'(col_q);
          res_o.row        = 12'(HT_W'(height_q - row_q - 1'b1));
          res_o.blue       = asm_nxt[7:0];
          res_o.green      = asm_nxt[15:8];
          res_o.red        = asm_nxt[23:16];
          res_o.last_pixel = last;
          col_d            = col_inc[WD_W-1:0];
          if (last) phase_d = PH_DONE;
        end
        if (rbc_inc >= {1'b0, line_len_q}) begin
          rbc_d = '0;
          col_d = '0;
          k_d   = 2'd0;
          row_d = row_inc[HT_W-1:0];
          if (row_inc >= {1'b0, height_q}) phase_d = PH_DONE;
        end else begin
          rbc_d = rbc_inc[LEN_W-1:0];
        end
      end

      if (eof_i) begin
        phase_d = PH_HEADER; dep_d = DEP_8;  bp_d = '0;   off_d = '0;
        raw_w_d = '0;        raw_h_d = '0;   sig_d = '0;  raw_d_d = '0;
        width_d = '0;        height_d = '0;  col_d = '0;  row_d = '0;
        data_len_d = '0;     line_len_d = '0; rbc_d = '0; k_d = 2'd0;
        asm_d = '0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_HEADER; dep_q <= DEP_8;  bp_q <= '0;   off_q <= '0;
      raw_w_q <= '0;        raw_h_q <= '0;   sig_q <= '0;  raw_d_q <= '0;
      width_q <= '0;        height_q <= '0;  col_q <= '0;  row_q <= '0;
      data_len_q <= '0;     line_len_q <= '0; rbc_q <= '0; k_q <= 2'd0;
      asm_q <= '0;
    end else begin
      phase_q <= phase_d;   dep_q <= dep_d;     bp_q <= bp_d;   off_q <= off_d;
      raw_w_q <= raw_w_d;   raw_h_q <= raw_h_d; sig_q <= sig_d; raw_d_q <= raw_d_d;
      width_q <= width_d;   height_q <= height_d; col_q <= col_d; row_q <= row_d;
      data_len_q <= data_len_d; line_len_q <= line_len_d; rbc_q <= rbc_d; k_q <= k_d;
      asm_q <= asm_d;
    end
  end

endmodule
